@@ src/bfei_pkg.sv @@
// bfei_pkg: shared types and constants for the bit field extract / insert core
// no dependencies; used by every file under src
`default_nettype none

package bfei_pkg;

  // fixed widths of the request and response fields
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned START_W  = 14;   // base plus offset, no wrap
  localparam int unsigned END_W    = 15;   // start plus length
  localparam int unsigned WIN_W    = 72;   // up to nine bytes of one field
  localparam int unsigned CNT_W    = 4;    // byte counters, 0 to 9
  localparam int unsigned SHAMT_W  = 7;    // shift amount into the window
  localparam int unsigned MAX_ADDR_W = 16; // byte address for the largest store

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_BASE_BIT = 1'b0;

  // request opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // response status
  localparam logic STS_DONE    = 1'b0;
  localparam logic STS_PAST_END = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [OFFSET_W-1:0] bit_offset;
    logic [LEN_W-1:0]    field_length;
    logic [VALUE_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               status;
  } rsp_t;

  // one read port and one write port into the byte store
  typedef struct packed {
    logic                  re;
    logic [MAX_ADDR_W-1:0] raddr;
    logic                  we;
    logic [MAX_ADDR_W-1:0] waddr;
    logic [7:0]            wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ACCESS,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ src/bit_field_extract_insert_core.sv @@
// bit_field_extract_insert_core: top level, sequencer and byte datapath
// depends on bfei_pkg, bfei_regs and bfei_store
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+-------------------------
//   request   | start in, busy out            | req_i  (bfei_pkg::req_t)
//   response  | done_o strobe, one cycle      | rsp_o  (bfei_pkg::rsp_t)
//   config    | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// - a request walks the bytes it touches one per cycle on the store's read port;
//   a field spanning n bytes (1 to 9) passes the setup, access and done states before its response
// - writes merge each byte as its read data returns, so read and write overlap
// - after reset the store is cleared one byte a cycle, with busy held high throughout
// - rejected requests (bad length, past end) skip setup and access and go straight to done
// - the response cannot be stalled; a new request may be taken while it shows
`default_nettype none

module bit_field_extract_insert_core #(
  parameter int unsigned STORE_BYTES    = 1024,
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire bfei_pkg::req_t                req_i,
  // response channel
  output logic                               done_o,
  output bfei_pkg::rsp_t                     rsp_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfei_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bfei_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bfei_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int unsigned ADDR_W     = $clog2(STORE_BYTES);
  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // configuration
  logic [bfei_pkg::OFFSET_W-1:0] base_bit;

  bfei_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_bit_o (base_bit)
  );

  // byte store
  bfei_pkg::mem_req_t mem_req;
  logic [7:0]         rdata;

  bfei_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // sequencer state
  bfei_pkg::state_e state_q, state_d;
  logic [ADDR_W-1:0]            clr_q, clr_d;
  logic [bfei_pkg::CNT_W-1:0]   iss_q, iss_d;     // bytes requested
  logic [bfei_pkg::CNT_W-1:0]   rcnt_q, rcnt_d;   // bytes returned
  logic                         rv_q, rv_d;       // read data valid next cycle
  logic                         done_q, done_d;

  // request payload held for the whole item
  logic                           op_q;
  logic                           err_q;
  logic [bfei_pkg::START_W-1:0]   start_q;
  logic [bfei_pkg::END_W-1:0]     end_q;
  logic [bfei_pkg::LEN_W-1:0]     len_q;
  logic [bfei_pkg::VALUE_W-1:0]   wval_q;
  logic [bfei_pkg::VALUE_W-1:0]   mask_q;
  logic [bfei_pkg::MAX_ADDR_W-1:0] first_q;
  logic [bfei_pkg::CNT_W-1:0]     n_q;
  logic [2:0]                     pad_q;
  logic [bfei_pkg::WIN_W-1:0]     window_q, wdat_q, wmsk_q;
  bfei_pkg::rsp_t                 rsp_q, rsp_d;

  // request decode at accept
  logic                         accept;
  logic [bfei_pkg::START_W-1:0] start_pos;
  logic [bfei_pkg::END_W-1:0]   end_pos;
  logic                         req_err;

  assign accept    = start && !busy;
  assign start_pos = bfei_pkg::START_W'(base_bit) + bfei_pkg::START_W'(req_i.bit_offset);
  assign end_pos   = bfei_pkg::END_W'(start_pos) + bfei_pkg::END_W'(req_i.field_length);
  assign req_err   = (req_i.field_length == '0)
                  || (32'(req_i.field_length) > MAX_FIELD_BITS)
                  || (32'(end_pos) > STORE_BITS);

  // setup decode: byte span and alignment of the field
  logic [bfei_pkg::END_W-1:0]     last_bit;
  logic [bfei_pkg::MAX_ADDR_W-1:0] first_byte, last_byte;
  logic [bfei_pkg::CNT_W-1:0]     n_bytes;
  logic [2:0]                     pad;
  logic [bfei_pkg::SHAMT_W-1:0]   wr_shamt;
  logic [bfei_pkg::VALUE_W-1:0]   len_mask;

  assign last_bit   = end_q - bfei_pkg::END_W'(1);
  assign first_byte = bfei_pkg::MAX_ADDR_W'(start_q >> 3);
  assign last_byte  = bfei_pkg::MAX_ADDR_W'(last_bit >> 3);
  assign n_bytes    = bfei_pkg::CNT_W'(last_byte - first_byte + bfei_pkg::MAX_ADDR_W'(1));
  assign pad        = ~last_bit[2:0];
  // place the first byte of the field at the top of the window
  assign wr_shamt   = bfei_pkg::SHAMT_W'(pad)
                    + bfei_pkg::SHAMT_W'({(4'd9 - n_bytes), 3'b000});
  assign len_mask   = {bfei_pkg::VALUE_W{1'b1}}
                    >> (bfei_pkg::LEN_W'(bfei_pkg::VALUE_W) - len_q);

  // extracted field once all bytes are in the window
  logic [bfei_pkg::WIN_W-1:0] win_shifted;
  assign win_shifted = window_q >> pad_q;

  // merged byte for insert
  logic [7:0] merged;
  assign merged = (rdata & ~wmsk_q[bfei_pkg::WIN_W-1 -: 8])
                | (wdat_q[bfei_pkg::WIN_W-1 -: 8] & wmsk_q[bfei_pkg::WIN_W-1 -: 8]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfei_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = bfei_pkg::ST_IDLE;
        end
      end
      bfei_pkg::ST_IDLE: begin
        if (start) begin
          state_d = req_err ? bfei_pkg::ST_DONE : bfei_pkg::ST_SETUP;
        end
      end
      bfei_pkg::ST_SETUP: begin
        state_d = bfei_pkg::ST_ACCESS;
      end
      bfei_pkg::ST_ACCESS: begin
        if (rv_q && (rcnt_q == n_q - bfei_pkg::CNT_W'(1))) begin
          state_d = bfei_pkg::ST_DONE;
        end
      end
      bfei_pkg::ST_DONE: begin
        state_d = bfei_pkg::ST_IDLE;
      end
      default: state_d = bfei_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_req = '0;
    busy    = 1'b1;
    clr_d   = clr_q;
    iss_d   = iss_q;
    rcnt_d  = rcnt_q;
    rv_d    = 1'b0;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    unique case (state_q)
      bfei_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = bfei_pkg::MAX_ADDR_W'(clr_q);
        mem_req.wdata = '0;
        clr_d         = clr_q + ADDR_W'(1);
      end
      bfei_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      bfei_pkg::ST_SETUP: begin
        iss_d  = '0;
        rcnt_d = '0;
      end
      bfei_pkg::ST_ACCESS: begin
        mem_req.re    = (iss_q < n_q);
        mem_req.raddr = first_q + bfei_pkg::MAX_ADDR_W'(iss_q);
        iss_d         = iss_q + bfei_pkg::CNT_W'(mem_req.re);
        rv_d          = mem_req.re;
        if (rv_q) begin
          mem_req.we    = (op_q == bfei_pkg::OP_WRITE);
          mem_req.waddr = first_q + bfei_pkg::MAX_ADDR_W'(rcnt_q);
          mem_req.wdata = merged;
          rcnt_d        = rcnt_q + bfei_pkg::CNT_W'(1);
        end
      end
      bfei_pkg::ST_DONE: begin
        done_d = 1'b1;
        if (err_q) begin
          rsp_d.read_value = '0;
          rsp_d.status     = bfei_pkg::STS_PAST_END;
        end else begin
          rsp_d.status     = bfei_pkg::STS_DONE;
          rsp_d.read_value = (op_q == bfei_pkg::OP_READ)
                           ? (bfei_pkg::VALUE_W'(win_shifted) & mask_q) : '0;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfei_pkg::ST_CLEAR;
      clr_q   <= '0;
      iss_q   <= '0;
      rcnt_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      iss_q   <= iss_d;
      rcnt_q  <= rcnt_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      op_q    <= req_i.opcode;
      err_q   <= req_err;
      start_q <= start_pos;
      end_q   <= end_pos;
      len_q   <= req_i.field_length;
      wval_q  <= req_i.write_value;
    end
    if (state_q == bfei_pkg::ST_SETUP) begin
      first_q  <= first_byte;
      n_q      <= n_bytes;
      pad_q    <= pad;
      mask_q   <= len_mask;
      window_q <= '0;
      wdat_q   <= bfei_pkg::WIN_W'(wval_q & len_mask) << wr_shamt;
      wmsk_q   <= bfei_pkg::WIN_W'(len_mask) << wr_shamt;
    end
    if ((state_q == bfei_pkg::ST_ACCESS) && rv_q) begin
      window_q <= {window_q[bfei_pkg::WIN_W-9:0], rdata};
      wdat_q   <= {wdat_q[bfei_pkg::WIN_W-9:0], 8'h00};
      wmsk_q   <= {wmsk_q[bfei_pkg::WIN_W-9:0], 8'h00};
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // a rejected request never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == bfei_pkg::STS_PAST_END)) |-> (rsp_o.read_value == '0))
    else $error("rejected request returned data");

  // an accepted request holds the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy low after request accepted");

  // returned bytes never run past the span of the field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfei_pkg::ST_ACCESS) |-> ((rcnt_q < n_q) && (iss_q <= n_q)))
    else $error("byte counter past field span");

  // the store is only written while clearing or merging a field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> ((state_q == bfei_pkg::ST_CLEAR)
                 || ((state_q == bfei_pkg::ST_ACCESS) && rv_q && (op_q == bfei_pkg::OP_WRITE))))
    else $error("unexpected store write");

  // the response strobe lasts exactly one cycle per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe held");
`endif

endmodule

`default_nettype wire

@@ src/bfei_store.sv @@
// bfei_store: byte store with one write port and one registered read port
// depends on bfei_pkg for the port request struct
`default_nettype none

module bfei_store #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  wire logic              clk_i,
  input  wire bfei_pkg::mem_req_t mem_req_i,
  output logic [7:0]             rdata_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr[ADDR_W-1:0]] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr[ADDR_W-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/bfei_regs.sv @@
// bfei_regs: apb-style configuration register holding the base bit position
// depends on bfei_pkg for port widths and register index
`default_nettype none

module bfei_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bfei_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bfei_pkg::PDATA_W-1:0]   pwdata,
  output logic      [bfei_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output logic      [bfei_pkg::OFFSET_W-1:0]  base_bit_o
);

  logic [bfei_pkg::OFFSET_W-1:0] base_q, base_d;
  logic                          wr_en;

  // word index sits above the byte lanes
  assign wr_en = psel && penable && pwrite && (paddr[2] == bfei_pkg::REG_BASE_BIT);

  always_comb begin
    base_d = base_q;
    if (wr_en) begin
      base_d = pwdata[bfei_pkg::OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfei_pkg::REG_BASE_BIT) begin
      prdata = {{(bfei_pkg::PDATA_W - bfei_pkg::OFFSET_W){1'b0}}, base_q};
    end
  end

  assign pready     = 1'b1;
  assign base_bit_o = base_q;

endmodule

`default_nettype wire

@@ test/bfei_field_monitor.sv @@
`timescale 1ns / 1ps
// bfei_field_monitor: watches the request, response and register ports of the core,
// keeps its own copy of the byte store and checks every response; needs bfei_pkg
module bfei_field_monitor
  import bfei_pkg::*;
#(
  parameter int unsigned STORE_BYTES    = 1024,
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  req_t               req,
  input  logic               done,
  input  rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);

  localparam int unsigned STORE_BITS  = STORE_BYTES * 8;

  logic [7:0]          store_mirror [STORE_BYTES];
  logic [OFFSET_W-1:0] base_bit_mirror;
  rsp_t                expected_rsp_q [$];
  int unsigned         mismatches = 0;
  int unsigned         queued = 0;

  assign fail_count    = mismatches;
  assign pending_count = queued;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // carries out one request on the mirror, returns the response it should give
  function automatic rsp_t apply_field_op(input req_t r);
    rsp_t        res;
    int unsigned first_bit;
    int unsigned len;
    int unsigned pos;
    int unsigned i;
    res        = '0;
    res.status = STS_DONE;
    first_bit  = base_bit_mirror + r.bit_offset;
    len        = r.field_length;
    if (len == 0 || len > MAX_FIELD_BITS || first_bit + len > STORE_BITS) begin
      res.status = STS_PAST_END;
      return res;
    end
    for (i = 0; i < len; i++) begin
      pos = first_bit + i;
      // msb of each byte holds the lowest bit position
      if (r.opcode == OP_READ) begin
        res.read_value = {res.read_value[VALUE_W-2:0], store_mirror[pos >> 3][7 - (pos % 8)]};
      end else begin
        store_mirror[pos >> 3][7 - (pos % 8)] = r.write_value[len - 1 - i];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      foreach (store_mirror[k]) store_mirror[k] = '0;
      base_bit_mirror = '0;
      expected_rsp_q.delete();
      queued <= 0;
    end else begin
      // retire before accepting, a new request may be taken while a response shows
      if (done === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp.read_value, want.read_value));
          end
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %b, expected %b", rsp.status, want.status));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_rsp_q.push_back(apply_field_op(req));
      end
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 &&
          paddr[PADDR_W-1:2] == REG_BASE_BIT) begin
        if (pwrite) begin
          base_bit_mirror = pwdata[OFFSET_W-1:0];
        end else if (prdata !== PDATA_W'(base_bit_mirror)) begin
          report_mismatch($sformatf("base_bit reads %h, expected %h", prdata, base_bit_mirror));
        end
      end
      queued <= expected_rsp_q.size();
    end
  end

endmodule

@@ test/tb_bit_field_extract_insert_core.sv @@
`timescale 1ns / 1ps
// tb_bit_field_extract_insert_core: stimulus and verdict for the field extract / insert core
// needs bfei_pkg, bit_field_extract_insert_core and bfei_field_monitor
module tb_bit_field_extract_insert_core;
  import bfei_pkg::*;

  localparam int unsigned STORE_BYTES    = 1024;
  localparam int unsigned STORE_BITS     = STORE_BYTES * 8;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned LAST_BIT       = STORE_BITS - 1;
  // the store clear after reset alone keeps the core quiet while it walks every byte of the store
  localparam int unsigned STALL_LIMIT    = 5000;
  // longest field is nine bytes; leave some margin
  localparam int unsigned SETTLE_CYCLES  = 20;

  logic               clk_i;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  req_t               req     = '0;
  logic               done;
  rsp_t               rsp;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned pending_rsp;
  int unsigned quiet_cycles = 0;
  // stimulus side copy of base_bit, only used to aim fields inside the store
  int unsigned cur_base     = 0;
  // chance in a hundred that the sender idles before a request, drawn anew after each idle cycle
  int unsigned idle_pct     = 0;

  bit_field_extract_insert_core #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .done_o  (done),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfei_field_monitor #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .rsp           (rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (mismatches),
    .pending_count (pending_rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: cycles in which no request, response or register access completes
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done === 1'b1 || (psel && penable && pready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic req_t mk_req(input logic op, input int unsigned offset,
                                  input int unsigned len, input logic [VALUE_W-1:0] value);
    req_t r;
    r.opcode       = op;
    r.bit_offset   = OFFSET_W'(offset);
    r.field_length = LEN_W'(len);
    r.write_value  = value;
    return r;
  endfunction

  // mostly fields that fit behind the current base, half of them packed into a
  // small window so reads land on earlier writes; the rest is raw noise
  function automatic req_t random_req();
    req_t        r;
    int unsigned len;
    int unsigned room;
    int unsigned span;
    r.opcode      = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
    r.write_value = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) begin
      r.bit_offset   = OFFSET_W'($urandom);
      r.field_length = LEN_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       len = MAX_FIELD_BITS;
        1:       len = $urandom_range(1, 8);
        default: len = $urandom_range(1, MAX_FIELD_BITS);
      endcase
      if (cur_base + len > STORE_BITS) len = STORE_BITS - cur_base;
      room = STORE_BITS - cur_base - len;
      span = ($urandom_range(0, 1) == 1 && room > 255) ? 255 : room;
      r.bit_offset   = OFFSET_W'($urandom_range(0, span));
      r.field_length = LEN_W'(len);
    end
    return r;
  endfunction

  // hold start high until the core takes the request; start stays high into the
  // next request unless the sender decides to idle first
  task automatic issue_req(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // stop sending and wait for every response still owed
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle between accesses
    @(posedge clk_i);
  endtask

  // register changes only once the core has gone quiet; read back for the monitor
  task automatic set_base(input int unsigned value);
    wait_drained();
    apb_access(1'b1, REG_BASE_BIT, PDATA_W'(value));
    apb_access(1'b0, REG_BASE_BIT, '0);
    cur_base = value;
  endtask

  task automatic run_random(input int unsigned base, input int unsigned pct,
                            input int unsigned count);
    set_base(base);
    idle_pct = pct;
    repeat (count) issue_req(random_req());
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // store clear after reset keeps busy high
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);

    // directed, base at zero, no idling
    set_base(0);
    idle_pct = 0;
    issue_req(mk_req(OP_READ,  0, 64, '0));                         // untouched store reads zero
    issue_req(mk_req(OP_WRITE, 0, 64, 64'hFFFF_FFFF_FFFF_FFFF));
    issue_req(mk_req(OP_READ,  0, 64, '1));                         // value ignored on reads
    issue_req(mk_req(OP_WRITE, 3, 64, 64'hA5C3_0F96_1234_8001));    // spans nine bytes
    issue_req(mk_req(OP_READ,  0, 8, '0));
    issue_req(mk_req(OP_READ,  3, 64, '0));
    issue_req(mk_req(OP_READ,  60, 10, '0));
    issue_req(mk_req(OP_WRITE, 5, 13, 64'hDEAD_BEEF_0000_1555));    // upper bits must not leak
    issue_req(mk_req(OP_READ,  0, 32, '0));
    issue_req(mk_req(OP_WRITE, LAST_BIT, 1, 64'h1));                // very last bit
    issue_req(mk_req(OP_READ,  LAST_BIT, 1, '0));
    issue_req(mk_req(OP_WRITE, STORE_BITS - 64, 64, 64'h8000_0000_0000_0001));
    issue_req(mk_req(OP_READ,  STORE_BITS - 64, 64, '0));           // ends exactly at the top
    issue_req(mk_req(OP_READ,  STORE_BITS - 63, 64, '0));           // one bit past the end
    issue_req(mk_req(OP_WRITE, STORE_BITS - 63, 64, '1));           // rejected, store unchanged
    issue_req(mk_req(OP_READ,  STORE_BITS - 64, 64, '0));
    issue_req(mk_req(OP_READ,  0, 0, '0));                          // zero length
    issue_req(mk_req(OP_WRITE, 0, 0, '1));
    issue_req(mk_req(OP_READ,  0, 65, '0));                         // longer than allowed
    issue_req(mk_req(OP_WRITE, 0, 127, '1));
    issue_req(mk_req(OP_WRITE, 4096, 7, 64'h55));
    issue_req(mk_req(OP_READ,  4090, 20, '0));

    // base at its top: only the single last bit is reachable
    set_base(LAST_BIT);
    idle_pct = 19;
    issue_req(mk_req(OP_WRITE, 0, 1, 64'h0));
    issue_req(mk_req(OP_READ,  0, 1, '0));
    issue_req(mk_req(OP_READ,  0, 2, '0));                          // past end
    issue_req(mk_req(OP_READ,  LAST_BIT, 64, '0));                  // start at its highest, no wrap
    issue_req(mk_req(OP_WRITE, LAST_BIT, 1, '1));
    repeat (15) issue_req(random_req());

    run_random($urandom_range(1, LAST_BIT - 1), 73, 150);
    run_random(0, 0, 160);
    run_random($urandom_range(1, LAST_BIT - 1), 19, 160);

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
